// ----- sv/pbs_pkg.sv -----
// shared types, constants and helper functions for the path blocklist set
// no dependencies
package pbs_pkg;

   localparam int MAX_LEN = 256;
   localparam int ENTRIES = 32;
   localparam int CHAR_W  = 16;
   localparam int POS_W   = $clog2(MAX_LEN);
   localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int ROW_W   = ENTRIES * CHAR_W;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_DUP      = 3'd1;
   localparam logic [2:0] ST_NOTFOUND = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_TOOLONG  = 3'd4;

   localparam logic [CHAR_W-1:0] CH_LOWER_A = 16'h0061;
   localparam logic [CHAR_W-1:0] CH_LOWER_Z = 16'h007A;
   localparam logic [CHAR_W-1:0] CH_CASE    = 16'h0020;
   localparam logic [CHAR_W-1:0] CH_SLASH   = 16'h002F;
   localparam logic [CHAR_W-1:0] CH_BSLASH  = 16'h005C;

   typedef struct packed {
      logic capture;
      logic compare;
      logic evaluate;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic char_ok;
      logic last;
   } dp_stat_type;

   function automatic logic [CHAR_W-1:0] normalize(input logic [CHAR_W-1:0] ch);
      logic [CHAR_W-1:0] r;
      r = ch;
      if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) r = ch - CH_CASE;
      if (ch == CH_SLASH) r = CH_BSLASH;
      return r;
   endfunction

   function automatic logic [SLOT_W-1:0] first_set(input logic [ENTRIES-1:0] vec);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int s = ENTRIES - 1; s >= 0; s--) begin
         if (vec[s]) idx = SLOT_W'(s);
      end
      return idx;
   endfunction

endpackage

// ----- sv/pbs_ctrl.sv -----
// controller state machine for the path blocklist set
// depends on pbs_pkg
module pbs_ctrl import pbs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [1:0] {S_IDLE, S_CMP, S_EVAL, S_DONE} state_type;

   state_type state_ff, state_in;
   logic      last_ff, last_in;
   logic      accept;

   assign accept = start && (state_ff == S_IDLE);
   assign busy   = (state_ff != S_IDLE);

   assign cmd.capture  = accept;
   assign cmd.compare  = (state_ff == S_CMP);
   assign cmd.evaluate = (state_ff == S_EVAL);
   assign cmd.finish   = (state_ff == S_DONE);

   always_comb begin
      state_in = state_ff;
      last_in  = last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               last_in = stat.last;
               if (stat.char_ok) state_in = S_CMP;
               else if (stat.last) state_in = S_EVAL;
            end
         end
         S_CMP:  state_in = last_ff ? S_EVAL : S_IDLE;
         S_EVAL: state_in = S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

endmodule

// ----- sv/pbs_datapath.sv -----
// datapath: character table, per-slot match state, slot bookkeeping, result registers
// depends on pbs_pkg
module pbs_datapath import pbs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_stat_type       stat,
   input  logic [1:0]        req_operation,
   input  logic              req_char_present,
   input  logic [CHAR_W-1:0] req_path_char,
   input  logic              req_last_char,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic              rsp_blocked,
   output logic [5:0]        rsp_entry_count
);

   logic [ROW_W-1:0]  mem [MAX_LEN];
   logic [ROW_W-1:0]  rd_ff;
   logic [POS_W-1:0]  len_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic [ENTRIES-1:0] match_ff;
   logic [ENTRIES-1:0] hit_ff;
   logic [POS_W-1:0]  pos_ff;
   logic              too_long_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [1:0]        op_ff;
   logic [CHAR_W-1:0] char_ff;
   logic              rsp_valid_ff;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic              rsp_blocked_ff, rsp_blocked_in;
   logic [CNT_W-1:0]  rsp_count_ff;

   logic              has_char, pos_full, table_full, found, add_ok;
   logic [SLOT_W-1:0] free_slot, hit_slot;

   assign has_char     = req_char_present && (req_path_char != '0);
   assign pos_full     = (pos_ff == POS_W'(MAX_LEN - 1));
   assign stat.char_ok = has_char && !pos_full;
   assign stat.last    = req_last_char;

   assign free_slot  = first_set(~valid_ff);
   assign hit_slot   = first_set(hit_ff);
   assign found      = |hit_ff;
   assign table_full = (count_ff >= CNT_W'(ENTRIES));
   assign add_ok     = !too_long_ff && (op_ff == OP_ADD) && !found && !table_full;

   always_comb begin
      valid_in       = valid_ff;
      count_in       = count_ff;
      rsp_status_in  = ST_OK;
      rsp_blocked_in = 1'b0;
      if (too_long_ff) begin
         rsp_status_in = ST_TOOLONG;
      end else begin
         unique case (op_ff)
            OP_ADD: begin
               if (found) rsp_status_in = ST_DUP;
               else if (table_full) rsp_status_in = ST_FULL;
               else begin
                  valid_in[free_slot] = 1'b1;
                  count_in            = count_ff + 1'b1;
               end
            end
            OP_REMOVE: begin
               if (found) begin
                  valid_in[hit_slot] = 1'b0;
                  if (count_ff != '0) count_in = count_ff - 1'b1;
               end else begin
                  rsp_status_in = ST_NOTFOUND;
               end
            end
            default: rsp_blocked_in = found;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_ff   <= mem[pos_ff];
         op_ff   <= req_operation;
         char_ff <= normalize(req_path_char);
      end
      if (cmd.compare && !table_full) begin
         mem[pos_ff][free_slot*CHAR_W +: CHAR_W] <= char_ff;
      end
      if (cmd.evaluate) begin
         for (int s = 0; s < ENTRIES; s++) begin
            hit_ff[s] <= valid_ff[s] && match_ff[s] && (len_ff[s] == pos_ff);
         end
      end
      if (cmd.finish) begin
         if (add_ok) len_ff[free_slot] <= pos_ff;
         rsp_status_ff  <= rsp_status_in;
         rsp_blocked_ff <= rsp_blocked_in;
         rsp_count_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         count_ff     <= '0;
         match_ff     <= '1;
         pos_ff       <= '0;
         too_long_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
         if (cmd.capture && has_char && pos_full) too_long_ff <= 1'b1;
         if (cmd.compare) begin
            for (int s = 0; s < ENTRIES; s++) begin
               if (valid_ff[s] && !((pos_ff < len_ff[s]) &&
                   (rd_ff[s*CHAR_W +: CHAR_W] == char_ff))) begin
                  match_ff[s] <= 1'b0;
               end
            end
            pos_ff <= pos_ff + 1'b1;
         end
         if (cmd.finish) begin
            valid_ff    <= valid_in;
            count_ff    <= count_in;
            match_ff    <= '1;
            pos_ff      <= '0;
            too_long_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_blocked     = rsp_blocked_ff;
   assign rsp_entry_count = 6'(rsp_count_ff);

endmodule

// ----- sv/path_blocklist_set_core.sv -----
// top level of the path blocklist set: controller plus datapath
// depends on pbs_pkg, pbs_ctrl, pbs_datapath
//
// channel   ports                                   handshake
// request   req_operation/char_present/path_char/   start high, busy low
//           last_char
// response  rsp_status/blocked/entry_count          rsp_valid, one cycle, no stall
//
// a character item reads the table row at accept, then compares and writes in S_CMP
// an item with no character skips the compare state
// a last item adds S_EVAL (hit vector), then S_DONE (slot update); rsp_valid follows
// reset clears slot valid bits, count and per-path state; no clearing pass
// the receiver cannot stall; busy alone holds off new transactions
module path_blocklist_set_core import pbs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_operation,
   input  logic              req_char_present,
   input  logic [CHAR_W-1:0] req_path_char,
   input  logic              req_last_char,
   output logic              rsp_valid,
   output logic [2:0]        rsp_status,
   output logic              rsp_blocked,
   output logic [5:0]        rsp_entry_count
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   pbs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   pbs_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_operation    (req_operation),
      .req_char_present (req_char_present),
      .req_path_char    (req_path_char),
      .req_last_char    (req_last_char),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_blocked      (rsp_blocked),
      .rsp_entry_count  (rsp_entry_count)
   );

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("response while busy");

   a_blocked_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_blocked |-> rsp_status == ST_OK) else $error("blocked with error status");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= 6'(ENTRIES)) else $error("entry count out of range");

   a_one_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back to back responses");

endmodule
